// File: rtl/fss_pkg.sv
// fss_pkg: shared types and constants for the frame step sequencer
// item and result payload structs, register indexes, action codes
// no dependencies
package fss_pkg;

	localparam int MAX_STEPS = 16;
	localparam int STEP_W    = 4;
	localparam int COUNT_W   = 5;
	localparam int MS_W      = 16;
	localparam int CD_W      = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MODE = 2'd2;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_RESTART = 2'd1,
		ACT_JUMP    = 2'd2,
		ACT_WRITE   = 2'd3
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [MS_W-1:0]   delta_ms;
		logic [STEP_W-1:0] step_index;
		logic [MS_W-1:0]   duration_ms;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0]      current_step;
		logic                   finished;
		logic signed [CD_W-1:0] remaining_ms;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] step_count;
		logic               loop_enable;
		logic               reverse_mode;
	} cfg_t;

endpackage

// File: rtl/fss_engine.sv
// fss_engine: sequencer state, duration table and the per-item update logic
// depends on fss_pkg
module fss_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  fss_pkg::item_t  item,
	input  fss_pkg::cfg_t   cfg,
	output fss_pkg::result_t res
);

	localparam int W34 = fss_pkg::CD_W + 2;
	localparam logic signed [W34-1:0] CD_MIN = 34'sh3_8000_0000;

	logic [fss_pkg::MS_W-1:0]          dur_tab_q [fss_pkg::MAX_STEPS];
	logic [fss_pkg::STEP_W-1:0]        step_q;
	logic signed [fss_pkg::CD_W-1:0]   cd_q;
	logic                              end_q;

	logic [fss_pkg::COUNT_W-1:0]       cnt;
	logic signed [W34-1:0]             cd_ext;
	logic signed [W34-1:0]             diff;
	logic signed [fss_pkg::CD_W-1:0]   cd_sat;
	logic [fss_pkg::STEP_W-1:0]        nxt;
	logic                              wrap;
	logic [fss_pkg::STEP_W-1:0]        rd_addr;
	logic [fss_pkg::MS_W-1:0]          dur;
	logic signed [W34-1:0]             base;
	logic signed [W34-1:0]             sum;
	logic signed [W34-1:0]             half;
	logic signed [fss_pkg::CD_W-1:0]   start;
	logic [fss_pkg::STEP_W-1:0]        step_n;
	logic signed [fss_pkg::CD_W-1:0]   cd_n;
	logic                              end_n;

	always_comb begin
		cnt = (cfg.step_count > fss_pkg::COUNT_W'(fss_pkg::MAX_STEPS))
			? fss_pkg::COUNT_W'(fss_pkg::MAX_STEPS) : cfg.step_count;
		cd_ext = {{2{cd_q[fss_pkg::CD_W-1]}}, cd_q};
		diff   = cd_ext - $signed({18'd0, item.delta_ms});
		cd_sat = (diff < CD_MIN) ? 32'sh8000_0000 : diff[fss_pkg::CD_W-1:0];

		// neighbor step, independent of the countdown so the table read runs in parallel
		wrap = 1'b0;
		if (cfg.reverse_mode) begin
			if (step_q != '0) begin
				nxt = step_q - 4'd1;
			end else begin
				wrap = 1'b1;
				nxt  = fss_pkg::STEP_W'(cnt - 5'd1);
			end
		end else begin
			if (({1'b0, step_q} + 5'd1) < cnt) begin
				nxt = step_q + 4'd1;
			end else begin
				wrap = 1'b1;
				nxt  = '0;
			end
		end

		case (item.action)
			fss_pkg::ACT_JUMP:    rd_addr = item.step_index;
			fss_pkg::ACT_RESTART: rd_addr = '0;
			default:              rd_addr = nxt;
		endcase
		dur = dur_tab_q[rd_addr];

		// entry into a step: carry the overshoot but keep at least half the duration
		base = (item.action == fss_pkg::ACT_TICK) ? diff : cd_ext;
		sum  = base + $signed({18'd0, dur});
		half = $signed({19'd0, dur[fss_pkg::MS_W-1:1]});
		if (base >= 0) begin
			start = $signed({16'd0, dur});
		end else if (sum < half) begin
			start = half[fss_pkg::CD_W-1:0];
		end else begin
			start = sum[fss_pkg::CD_W-1:0];
		end

		step_n = step_q;
		cd_n   = cd_q;
		end_n  = end_q;
		case (item.action)
			fss_pkg::ACT_TICK: begin
				end_n = 1'b0;
				if (cnt != '0) begin
					cd_n = cd_sat;
					if (diff <= 0) begin
						end_n = wrap;
						if ((!wrap || cfg.loop_enable) && (nxt != step_q)
							&& ({1'b0, nxt} < cnt)) begin
							step_n = nxt;
							cd_n   = start;
						end
					end
				end
			end
			fss_pkg::ACT_RESTART: begin
				step_n = '0;
				end_n  = 1'b0;
				cd_n   = (cnt != '0) ? $signed({16'd0, dur}) : '0;
			end
			fss_pkg::ACT_JUMP: begin
				if ({1'b0, item.step_index} < cnt) begin
					step_n = item.step_index;
					cd_n   = start;
				end
			end
			default: ;
		endcase

		res.current_step = step_n;
		res.finished     = end_n;
		res.remaining_ms = cd_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cd_q   <= '0;
			end_q  <= 1'b0;
		end else if (fire) begin
			step_q <= step_n;
			cd_q   <= cd_n;
			end_q  <= end_n;
		end
	end

	// duration table holds no reset, entries are defined once written
	always_ff @(posedge clk) begin
		if (fire && (item.action == fss_pkg::ACT_WRITE)) begin
			dur_tab_q[item.step_index] <= item.duration_ms;
		end
	end

endmodule

// File: rtl/frame_step_sequencer.sv
// frame_step_sequencer: top level with item/result handshake and config registers
// depends on fss_pkg and fss_engine
//
// Takes one item per clock while the result side does not stall and returns
// exactly one result per item. An item is held in the input register, where
// the engine updates step, countdown and finished flag in a single pass, and
// the result is captured in the output register when the item moves on. The
// rate is set by the step/countdown state loop. The result register keeps its
// transfer pending under stall while the input register still holds the next
// item. Configuration is written through cfg_we/cfg_index/cfg_wdata while the
// block is idle, a rule for the user that the block does not enforce; index 0
// is step_count, 1 loop_enable, 2 reverse_mode, other indexes are ignored.
module frame_step_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  fss_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output fss_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [fss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	fss_pkg::cfg_t    cfg_q;
	fss_pkg::item_t   item_s1;
	logic             valid_s1;
	fss_pkg::result_t result_q;
	logic             result_valid_q;
	fss_pkg::result_t res;
	logic             fire;
	logic             accept;

	assign fire       = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !fire;
	assign accept     = item_valid && !item_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_count   <= '0;
			cfg_q.loop_enable  <= 1'b1;
			cfg_q.reverse_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				fss_pkg::REG_STEP_COUNT:   cfg_q.step_count   <= cfg_wdata;
				fss_pkg::REG_LOOP_ENABLE:  cfg_q.loop_enable  <= cfg_wdata[0];
				fss_pkg::REG_REVERSE_MODE: cfg_q.reverse_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_q <= res;
		end
	end

	fss_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// input side only stalls behind an item that could not move on
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item stall without a held item");

	// every processed item lands in the result register
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> result_valid_q)
		else $error("processed item produced no result");

	// restart always returns to the first step with the flag clear
	a_restart_home: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item_s1.action == fss_pkg::ACT_RESTART)
		|=> (result_q.current_step == '0) && !result_q.finished)
		else $error("restart did not return to the first step");

	// a result held under stall is not overwritten
	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_stall |-> !fire)
		else $error("pending result overwritten");

endmodule

// File: tb/frame_step_sequencer_tb.sv
// frame_step_sequencer_tb: self-checking bench for the frame step sequencer
// scoreboard class predicts step, finished flag and countdown per transfer
// depends on fss_pkg and frame_step_sequencer
`timescale 1ns / 1ps

module frame_step_sequencer_tb;

	localparam longint CD_FLOOR     = -64'sh80000000;
	localparam int     FLOOR_DIV    = 2;
	localparam int     HOLD_CYCLES  = 60;
	localparam int     SEG_ITEMS    = 75;
	localparam int     SINGLE_TICKS = 20;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	fss_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	fss_pkg::result_t result;
	logic             cfg_we;
	logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fss_pkg::CFG_DATA_W-1:0] cfg_wdata;

	int send_idle_pct;
	int recv_idle_pct;
	// toggled by the stimulus to ask the receiver for a long hold-off
	bit hold_req;

	frame_step_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	class step_scoreboard;
		logic [fss_pkg::MS_W-1:0]   durations [fss_pkg::MAX_STEPS];
		logic [fss_pkg::STEP_W-1:0] step_now;
		longint                     countdown;
		bit                         end_flag;
		int unsigned                step_count;
		bit                         loop_en;
		bit                         rev_mode;
		fss_pkg::result_t           expected_q [$];
		int                         errors;

		function new();
			step_now   = '0;
			countdown  = 0;
			end_flag   = 1'b0;
			step_count = 0;
			loop_en    = 1'b1;
			rev_mode   = 1'b0;
			errors     = 0;
		endfunction

		function void apply_register(logic [fss_pkg::CFG_IDX_W-1:0] idx,
			logic [fss_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				fss_pkg::REG_STEP_COUNT:   step_count = val;
				fss_pkg::REG_LOOP_ENABLE:  loop_en = val[0];
				fss_pkg::REG_REVERSE_MODE: rev_mode = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned active_steps();
			return (step_count > fss_pkg::MAX_STEPS) ? fss_pkg::MAX_STEPS : step_count;
		endfunction

		// new step keeps the overshoot but never starts below half its duration
		function void load_step(int unsigned target);
			longint dur;
			longint start;
			if (target >= active_steps())
				return;
			step_now = fss_pkg::STEP_W'(target);
			dur = longint'(durations[target]);
			start = (countdown >= 0) ? dur : dur + countdown;
			if (start < dur / FLOOR_DIV)
				start = dur / FLOOR_DIV;
			countdown = start;
		endfunction

		function void advance_step();
			int unsigned cnt;
			int unsigned cur;
			int unsigned nxt;
			cnt = active_steps();
			cur = step_now;
			if (rev_mode) begin
				if (cur > 0) begin
					nxt = cur - 1;
				end else begin
					end_flag = 1'b1;
					if (!loop_en)
						return;
					nxt = cnt - 1;
				end
			end else begin
				if (cur + 1 < cnt) begin
					nxt = cur + 1;
				end else begin
					end_flag = 1'b1;
					if (!loop_en)
						return;
					nxt = 0;
				end
			end
			if (nxt != cur)
				load_step(nxt);
		endfunction

		function void note_item(fss_pkg::item_t it);
			fss_pkg::result_t r;
			case (it.action)
				fss_pkg::ACT_TICK: begin
					end_flag = 1'b0;
					if (active_steps() != 0) begin
						countdown = countdown - longint'(it.delta_ms);
						if (countdown < CD_FLOOR)
							countdown = CD_FLOOR;
						if (countdown <= 0)
							advance_step();
					end
				end
				fss_pkg::ACT_RESTART: begin
					step_now  = '0;
					end_flag  = 1'b0;
					countdown = (active_steps() > 0) ? longint'(durations[0]) : 0;
				end
				fss_pkg::ACT_JUMP: load_step(it.step_index);
				default: durations[it.step_index] = it.duration_ms;
			endcase
			r.current_step = step_now;
			r.finished     = end_flag;
			r.remaining_ms = countdown[fss_pkg::CD_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(fss_pkg::result_t got);
			fss_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: current_step %0d finished %0d remaining_ms %0d",
					got.current_step, got.finished, $signed(got.remaining_ms));
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.current_step !== want.current_step) begin
				$error("current_step: expected %0d, got %0d",
					want.current_step, got.current_step);
				errors++;
			end
			if (got.finished !== want.finished) begin
				$error("finished: expected %0d, got %0d", want.finished, got.finished);
				errors++;
			end
			if (got.remaining_ms !== want.remaining_ms) begin
				$error("remaining_ms: expected %0d, got %0d",
					$signed(want.remaining_ms), $signed(got.remaining_ms));
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	step_scoreboard book = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stall, or a long hold-off when requested
	initial begin
		int hold_left;
		bit hold_seen;
		result_stall = 1'b0;
		hold_left    = 0;
		hold_seen    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			book.check_result(result);
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic fss_pkg::item_t pack_item(fss_pkg::action_t act,
		logic [fss_pkg::MS_W-1:0] delta, logic [fss_pkg::STEP_W-1:0] idx,
		logic [fss_pkg::MS_W-1:0] dur);
		fss_pkg::item_t it;
		it.action      = act;
		it.delta_ms    = delta;
		it.step_index  = idx;
		it.duration_ms = dur;
		return it;
	endfunction

	// mostly small times so steps actually advance, sometimes extremes
	function automatic logic [fss_pkg::MS_W-1:0] random_ms();
		case ($urandom_range(0, 9))
			0:       return fss_pkg::MS_W'($urandom_range(0, 65535));
			1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			2:       return fss_pkg::MS_W'($urandom_range(150, 2000));
			default: return fss_pkg::MS_W'($urandom_range(0, 150));
		endcase
	endfunction

	function automatic fss_pkg::item_t random_item();
		int unsigned      pick;
		fss_pkg::action_t act;
		pick = $urandom_range(0, 99);
		if (pick < 68)
			act = fss_pkg::ACT_TICK;
		else if (pick < 78)
			act = fss_pkg::ACT_RESTART;
		else if (pick < 90)
			act = fss_pkg::ACT_JUMP;
		else
			act = fss_pkg::ACT_WRITE;
		return pack_item(act, random_ms(), fss_pkg::STEP_W'($urandom_range(0, 15)),
			random_ms());
	endfunction

	task automatic send_item(input fss_pkg::item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		book.note_item(it);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input int unsigned cnt, input bit lp, input bit rv);
		cfg_we    <= 1'b1;
		cfg_index <= fss_pkg::REG_STEP_COUNT;
		cfg_wdata <= fss_pkg::CFG_DATA_W'(cnt);
		book.apply_register(fss_pkg::REG_STEP_COUNT, fss_pkg::CFG_DATA_W'(cnt));
		@(posedge clk);
		cfg_index <= fss_pkg::REG_LOOP_ENABLE;
		cfg_wdata <= fss_pkg::CFG_DATA_W'(lp);
		book.apply_register(fss_pkg::REG_LOOP_ENABLE, fss_pkg::CFG_DATA_W'(lp));
		@(posedge clk);
		cfg_index <= fss_pkg::REG_REVERSE_MODE;
		cfg_wdata <= fss_pkg::CFG_DATA_W'(rv);
		book.apply_register(fss_pkg::REG_REVERSE_MODE, fss_pkg::CFG_DATA_W'(rv));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned cnt;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		hold_req      = 1'b0;
		send_idle_pct = 7;
		recv_idle_pct = 83;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty animation: tick only clears the flag, restart zeroes, jump ignored
		send_item(pack_item(fss_pkg::ACT_TICK, 16'hFFFF, 4'd0, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_RESTART, 16'h0000, 4'd0, 16'hFFFF));
		send_item(pack_item(fss_pkg::ACT_JUMP, 16'h0000, 4'd15, 16'h0000));
		// fill the whole table before any step can be read
		send_item(pack_item(fss_pkg::ACT_WRITE, 16'h0000, 4'd0, 16'd40));
		send_item(pack_item(fss_pkg::ACT_WRITE, 16'h0000, 4'd1, 16'd0));
		send_item(pack_item(fss_pkg::ACT_WRITE, 16'h0000, 4'd2, 16'hFFFF));
		send_item(pack_item(fss_pkg::ACT_WRITE, 16'h0000, 4'd3, 16'd1));
		send_item(pack_item(fss_pkg::ACT_WRITE, 16'h0000, 4'd4, 16'h5555));
		send_item(pack_item(fss_pkg::ACT_WRITE, 16'h0000, 4'd5, 16'hAAAA));
		for (int i = 6; i < fss_pkg::MAX_STEPS; i++)
			send_item(pack_item(fss_pkg::ACT_WRITE, 16'h0000, fss_pkg::STEP_W'(i),
				fss_pkg::MS_W'(10 * i + 3)));
		wait_idle();

		// full count, parking at the end
		write_cfg(fss_pkg::MAX_STEPS, 1'b0, 1'b0);
		send_item(pack_item(fss_pkg::ACT_RESTART, 16'h0000, 4'd0, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_TICK, 16'h0000, 4'd0, 16'h0000));
		// overshoot into a zero-length step, then jumps from a settled countdown
		send_item(pack_item(fss_pkg::ACT_TICK, 16'd100, 4'd0, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_JUMP, 16'h0000, 4'd2, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_JUMP, 16'h0000, 4'd15, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_TICK, 16'hFFFF, 4'd0, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_TICK, 16'h0000, 4'd0, 16'h0000));
		wait_idle();

		// step 15 sits beyond the reduced count; reverse advance is ignored
		write_cfg(3, 1'b1, 1'b1);
		send_item(pack_item(fss_pkg::ACT_TICK, 16'd1, 4'd0, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_JUMP, 16'h0000, 4'd0, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_TICK, 16'hFFFF, 4'd0, 16'h0000));

		for (int s = 0; s < 12; s++) begin
			wait_idle();
			if (s == 4) begin
				send_idle_pct = 83;
				recv_idle_pct = 7;
			end else if (s == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (s % 4)
				0:       cnt = fss_pkg::MAX_STEPS;
				1:       cnt = $urandom_range(2, 15);
				2:       cnt = (s % 8 == 2) ? 1 : 0;
				default: cnt = $urandom_range(0, fss_pkg::MAX_STEPS);
			endcase
			write_cfg(cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			// long receiver hold-off while items keep coming
			if (s == 8)
				hold_req = ~hold_req;
			repeat (SEG_ITEMS)
				send_item(random_item());
		end

		// single step never reloads, so full ticks keep pulling the countdown down
		wait_idle();
		write_cfg(1, 1'b1, 1'b0);
		send_item(pack_item(fss_pkg::ACT_RESTART, 16'h0000, 4'd0, 16'h0000));
		repeat (SINGLE_TICKS)
			send_item(pack_item(fss_pkg::ACT_TICK, 16'hFFFF, 4'd0, 16'h0000));
		send_item(pack_item(fss_pkg::ACT_RESTART, 16'h0000, 4'd0, 16'h0000));

		wait_idle();
		repeat (10) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
rtl/fss_pkg.sv
rtl/fss_engine.sv
rtl/frame_step_sequencer.sv
tb/frame_step_sequencer_tb.sv
